### rtl/transparent_draw_order_sorter_top_assert.svh
// Assertion macros for the draw-order sorter top level
`ifndef TRANSPARENT_DRAW_ORDER_SORTER_TOP_ASSERT_SVH
`define TRANSPARENT_DRAW_ORDER_SORTER_TOP_ASSERT_SVH

// Check a property on each clock edge outside reset
`define TDOS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each clock edge, reset included
`define TDOS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tdos_pkg.sv
// Types and constants for the transparent draw-order sorter
package tdos_pkg;

    localparam int SORT_DEPTH = 32;
    localparam int TAG_BITS   = 16;
    localparam int KEY_BITS   = 31;
    localparam int CNT_W      = $clog2(SORT_DEPTH + 1);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        tag_t geometry_tag;
        logic transparent;
        key_t distance_key;
        logic last_item;
    } in_item_t;

    typedef struct packed {
        tag_t out_tag;
        logic last_result;
        logic overflow;
    } out_item_t;

    // Per-cell load selection, highest priority first
    typedef struct packed {
        logic load_in;
        logic from_up;
        logic from_down;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        STATE_FILL,
        STATE_SORT,
        STATE_DRAIN
    } state_t;

endpackage

### rtl/tdos_cell.sv
// One cell of the sorting chain: holds one key and tag, compares with its upper neighbour
module tdos_cell (
    input  logic                clk,
    input  tdos_pkg::cell_ctrl_t ctrl,
    input  logic                ascending,
    input  tdos_pkg::key_t      in_key,
    input  tdos_pkg::tag_t      in_tag,
    input  tdos_pkg::key_t      up_key,
    input  tdos_pkg::tag_t      up_tag,
    input  tdos_pkg::key_t      down_key,
    input  tdos_pkg::tag_t      down_tag,
    output tdos_pkg::key_t      key,
    output tdos_pkg::tag_t      tag,
    output logic                before_up
);

    tdos_pkg::key_t key_reg;
    tdos_pkg::key_t key_next;
    tdos_pkg::tag_t tag_reg;
    tdos_pkg::tag_t tag_next;

    // Select the new contents: fresh item, neighbour above, neighbour below, or hold
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        priority if (ctrl.load_in)
        begin
            key_next = in_key;
            tag_next = in_tag;
        end
        else if (ctrl.from_up)
        begin
            key_next = up_key;
            tag_next = up_tag;
        end
        else if (ctrl.from_down)
        begin
            key_next = down_key;
            tag_next = down_tag;
        end
        else
        begin
            key_next = key_reg;
            tag_next = tag_reg;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    // Upper neighbour must be drawn strictly earlier: swap only then, keeping ties stable
    assign before_up = ascending ? (up_key < key_reg) : (up_key > key_reg);

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

### rtl/transparent_draw_order_sorter_top.sv
// Top level of the transparent draw-order sorter: cell chain, sequencer and output register
//
//  Channel   | Signals                          | Moves
//  ----------+----------------------------------+-------------------------------------
//  input     | in_valid, in_ready, in_item      | one draw item per handshake
//  output    | out_valid, out_ready, out_item   | one tag in draw order per handshake
//  config    | cfg_wr_en, cfg_wr_data           | ascending_order, written at once
//
// Within a frame an item is taken every cycle while the output register is free.
// After the last item the chain runs N odd-even transposition passes (N = transparent
// items held, at most SORT_DEPTH), one pass per cycle, then drains one result a cycle.
// Input is held off during sorting and draining; an output stall holds the chain, but not the sort passes.
// Reset (rst_n low, asynchronous) empties the chain and returns to the fill state.
module transparent_draw_order_sorter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tdos_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdos_pkg::out_item_t  out_item,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    `include "transparent_draw_order_sorter_top_assert.svh"

    localparam int DEPTH = tdos_pkg::SORT_DEPTH;
    localparam int CW    = tdos_pkg::CNT_W;

    tdos_pkg::state_t    state_reg;
    tdos_pkg::state_t    state_next;
    tdos_pkg::cnt_t      count_reg;
    tdos_pkg::cnt_t      count_next;
    tdos_pkg::cnt_t      pass_reg;
    tdos_pkg::cnt_t      pass_next;
    logic                dropped_reg;
    logic                dropped_next;
    logic                ascending_reg;
    logic                ascending_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    tdos_pkg::out_item_t out_item_reg;
    tdos_pkg::out_item_t out_item_next;

    logic in_acc;
    logic out_free;
    logic full;
    logic fill_store;
    logic fill_drop;
    logic last_alone;
    logic sorting;
    logic drain_load;
    logic pass_done;

    tdos_pkg::key_t     cell_key [DEPTH];
    tdos_pkg::tag_t     cell_tag [DEPTH];
    logic               before_up [DEPTH];
    logic               swap [DEPTH];
    tdos_pkg::cell_ctrl_t ctrl [DEPTH];

    // Handshake and frame conditions
    assign out_free   = !out_valid_reg || out_ready;
    assign in_acc     = in_valid && in_ready;
    assign full       = (count_reg == CW'(DEPTH));
    assign fill_store = in_acc && in_item.transparent && !full;
    assign fill_drop  = in_acc && in_item.transparent && full;
    assign last_alone = in_item.last_item && !in_item.transparent && (count_reg == '0);
    assign pass_done  = (pass_reg == (count_reg - CW'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdos_pkg::STATE_FILL:
            begin
                if (in_acc && in_item.last_item && !last_alone)
                begin
                    state_next = tdos_pkg::STATE_SORT;
                end
            end
            tdos_pkg::STATE_SORT:
            begin
                if (pass_done)
                begin
                    state_next = tdos_pkg::STATE_DRAIN;
                end
            end
            tdos_pkg::STATE_DRAIN:
            begin
                if (drain_load && (count_reg == CW'(1)))
                begin
                    state_next = tdos_pkg::STATE_FILL;
                end
            end
            default:
            begin
                state_next = tdos_pkg::STATE_FILL;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready   = 1'b0;
        sorting    = 1'b0;
        drain_load = 1'b0;
        unique case (state_reg)
            tdos_pkg::STATE_FILL:  in_ready   = out_free;
            tdos_pkg::STATE_SORT:  sorting    = 1'b1;
            tdos_pkg::STATE_DRAIN: drain_load = out_free;
            default:
            begin
                in_ready   = 1'b0;
                sorting    = 1'b0;
                drain_load = 1'b0;
            end
        endcase
    end

    // Fill count, pass counter, drop flag and order register
    always_comb
    begin
        count_next     = count_reg;
        pass_next      = pass_reg;
        dropped_next   = dropped_reg;
        ascending_next = cfg_wr_en ? cfg_wr_data : ascending_reg;

        if (fill_store)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (drain_load)
        begin
            count_next = count_reg - CW'(1);
        end

        if (sorting)
        begin
            pass_next = pass_reg + CW'(1);
        end
        else
        begin
            pass_next = '0;
        end

        if (fill_drop)
        begin
            dropped_next = 1'b1;
        end
        else if ((in_acc && last_alone) || (drain_load && (count_reg == CW'(1))))
        begin
            dropped_next = 1'b0;
        end
    end

    // Output register: opaque item on entry, or head of chain while draining
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (in_acc && !in_item.transparent)
        begin
            out_valid_next            = 1'b1;
            out_item_next.out_tag     = in_item.geometry_tag;
            out_item_next.last_result = last_alone;
            out_item_next.overflow    = last_alone && dropped_reg;
        end
        else if (drain_load)
        begin
            out_valid_next            = 1'b1;
            out_item_next.out_tag     = cell_tag[0];
            out_item_next.last_result = (count_reg == CW'(1));
            out_item_next.overflow    = (count_reg == CW'(1)) && dropped_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdos_pkg::STATE_FILL;
            count_reg     <= '0;
            pass_reg      <= '0;
            dropped_reg   <= 1'b0;
            ascending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            dropped_reg   <= dropped_next;
            ascending_reg <= ascending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Chain of cells: write at the fill point, swap pairs while sorting, shift down to drain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int UpIdx   = (i + 1 < DEPTH) ? i + 1 : i;
        localparam int DownIdx = (i > 0) ? i - 1 : i;

        // Pair (i, i+1) takes part on passes of matching parity, inside the filled region
        assign swap[i] = sorting && (pass_reg[0] == 1'(i % 2))
                         && (CW'(i + 1) < count_reg) && before_up[i];

        assign ctrl[i].load_in = fill_store && (count_reg == CW'(i));
        assign ctrl[i].from_up = drain_load || swap[i];
        if (i > 0)
        begin : g_down
            assign ctrl[i].from_down = swap[DownIdx];
        end
        else
        begin : g_bottom
            assign ctrl[i].from_down = 1'b0;
        end

        tdos_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .ascending (ascending_reg),
            .in_key    (in_item.distance_key),
            .in_tag    (in_item.geometry_tag),
            .up_key    (cell_key[UpIdx]),
            .up_tag    (cell_tag[UpIdx]),
            .down_key  (cell_key[DownIdx]),
            .down_tag  (cell_tag[DownIdx]),
            .key       (cell_key[i]),
            .tag       (cell_tag[i]),
            .before_up (before_up[i])
        );
    end

    `TDOS_ASSERT(a_count_in_range, count_reg <= CW'(DEPTH), "fill count beyond chain depth")
    `TDOS_ASSERT(a_sort_not_empty, state_reg == tdos_pkg::STATE_SORT |-> count_reg != '0, "sorting an empty chain")
    `TDOS_ASSERT(a_overflow_on_last, out_valid && out_item.overflow |-> out_item.last_result, "overflow on a non-final result")
    `TDOS_ASSERT(a_drain_ends, drain_load && count_reg == CW'(1) |=> state_reg == tdos_pkg::STATE_FILL && count_reg == '0, "drain did not end the frame")
    `TDOS_ASSERT_ALWAYS(a_reset_state, !rst_n |-> state_reg == tdos_pkg::STATE_FILL && !out_valid_reg, "control not cleared in reset")

endmodule

### tb/sv/tb_transparent_draw_order_sorter_top.sv
// Self-checking testbench for the transparent draw-order sorter top level
module tb_transparent_draw_order_sorter_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = tdos_pkg::SORT_DEPTH + 16;
    localparam int HOLD_CYCLES  = 120;
    localparam int DIR_ROWS     = 19;

    // Directed plan: either a draw item or a write of the order register
    typedef enum logic {
        ROW_ITEM,
        ROW_ORDER
    } row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        logic           order;
        tdos_pkg::tag_t tag;
        logic           transp;
        tdos_pkg::key_t key;
        logic           last;
        logic           typed;
        tdos_pkg::tag_t want_tag;
        logic           want_last;
        logic           want_ovf;
    } plan_row_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b1;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    tdos_pkg::in_item_t  in_item     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    tdos_pkg::out_item_t out_item;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;

    // Predictor state: held transparent items of the open frame and the order register
    tdos_pkg::key_t      held_keys [tdos_pkg::SORT_DEPTH];
    tdos_pkg::tag_t      held_tags [tdos_pkg::SORT_DEPTH];
    int                  held_count  = 0;
    bit                  frame_lost  = 1'b0;
    bit                  near_first  = 1'b0;

    tdos_pkg::out_item_t draw_order_q [$];
    tdos_pkg::out_item_t want_item;
    int                  mismatches  = 0;

    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  hold_asks   = 0;
    int                  hold_done   = 0;
    int                  hold_left   = 0;

    plan_row_t plan [DIR_ROWS] = '{
        '{ROW_ITEM,  1'b0, 16'hFFFF, 1'b0, 31'h7FFFFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0000, 1'b0, 31'h00000000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0011, 1'b1, 31'h3F800000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0012, 1'b1, 31'h7FFFFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0013, 1'b1, 31'h00000000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0014, 1'b1, 31'h7F800000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0015, 1'b1, 31'h3F800000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0016, 1'b0, 31'h12345678, 1'b0, 1'b1, 16'h0016, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0017, 1'b1, 31'h7FC00000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0018, 1'b0, 31'h00000000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ORDER, 1'b1, 16'h0000, 1'b0, 31'h00000000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'hA5A5, 1'b1, 31'h40490FDB, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h5A5A, 1'b1, 31'h00000001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h0F0F, 1'b1, 31'h40490FDB, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'hF0F0, 1'b0, 31'h7FFFFFFF, 1'b0, 1'b1, 16'hF0F0, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h8001, 1'b1, 31'h7F800000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h7FFE, 1'b1, 31'h55555555, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ROW_ITEM,  1'b0, 16'h1234, 1'b0, 31'h2AAAAAAA, 1'b1, 1'b1, 16'h1234, 1'b1, 1'b0},
        '{ROW_ORDER, 1'b0, 16'h0000, 1'b0, 31'h00000000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}
    };

    transparent_draw_order_sorter_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the draw order that one accepted item releases
    task automatic predict_draw(input tdos_pkg::in_item_t it);
        tdos_pkg::key_t      sk [tdos_pkg::SORT_DEPTH];
        tdos_pkg::tag_t      st [tdos_pkg::SORT_DEPTH];
        tdos_pkg::key_t      k;
        tdos_pkg::tag_t      t;
        int                  j;
        int                  total;
        int                  idx;
        tdos_pkg::out_item_t r;
        if (it.transparent)
        begin
            if (held_count < tdos_pkg::SORT_DEPTH)
            begin
                held_keys[held_count] = it.distance_key;
                held_tags[held_count] = it.geometry_tag;
                held_count++;
            end
            else
                frame_lost = 1'b1;
        end
        total = (it.transparent ? 0 : 1) + (it.last_item ? held_count : 0);
        idx = 0;
        // Opaque items go straight out, ahead of any sorted ones
        if (!it.transparent)
        begin
            r.out_tag     = it.geometry_tag;
            r.last_result = it.last_item && (idx == total - 1);
            r.overflow    = r.last_result && frame_lost;
            draw_order_q.push_back(r);
            idx++;
        end
        if (it.last_item)
        begin
            // Stable insertion sort: equal keys keep arrival order
            for (int i = 0; i < held_count; i++)
            begin
                k = held_keys[i];
                t = held_tags[i];
                j = i;
                while (j > 0 && (near_first ? (k < sk[j-1]) : (k > sk[j-1])))
                begin
                    sk[j] = sk[j-1];
                    st[j] = st[j-1];
                    j--;
                end
                sk[j] = k;
                st[j] = t;
            end
            for (int i = 0; i < held_count; i++)
            begin
                r.out_tag     = st[i];
                r.last_result = (idx == total - 1);
                r.overflow    = r.last_result && frame_lost;
                draw_order_q.push_back(r);
                idx++;
            end
            held_count = 0;
            frame_lost = 1'b0;
        end
    endtask

    // Offer one item, with random gaps first, and record what it should release
    task automatic send_item(input tdos_pkg::in_item_t it, input bit typed,
                             input tdos_pkg::out_item_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (typed)
            draw_order_q.push_back(want);
        else
            predict_draw(it);
    endtask

    // Hold the input off until every expected result is out, then let the block settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (draw_order_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_order(input bit v);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        near_first = v;
    endtask

    // Random frames: mostly short, every fourth one long enough to overflow the store
    task automatic run_frames(input int budget, input bit with_hold);
        tdos_pkg::in_item_t it;
        int                 sent;
        int                 frame;
        int                 len;
        bit                 big;
        sent  = 0;
        frame = 0;
        while (sent < budget)
        begin
            if (frame == 2)
                wait_drain();
            if (with_hold && frame == 1)
                hold_asks++;
            big = (frame % 4 == 3);
            len = big ? $urandom_range(tdos_pkg::SORT_DEPTH + 1, tdos_pkg::SORT_DEPTH + 6)
                      : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                it.geometry_tag = tdos_pkg::tag_t'($urandom_range(0, 65535));
                it.transparent  = $urandom_range(99) < (big ? 95 : 60);
                case ($urandom_range(0, 5))
                    0: it.distance_key = '0;
                    1: it.distance_key = 31'h7FFFFFFF;
                    2: it.distance_key = 31'h3F800000
                                         + tdos_pkg::key_t'($urandom_range(0, 1));
                    3: it.distance_key = 31'h7F800000
                                         + tdos_pkg::key_t'($urandom_range(0, 3));
                    default: it.distance_key = tdos_pkg::key_t'($urandom());
                endcase
                it.last_item = (i == len - 1);
                send_item(it, 1'b0, '0);
            end
            sent += len;
            frame++;
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_asks != hold_done)
        begin
            hold_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (draw_order_q.size() == 0)
            begin
                $error("unexpected result: out_tag %h last_result %b overflow %b",
                       out_item.out_tag, out_item.last_result, out_item.overflow);
                mismatches++;
            end
            else
            begin
                want_item = draw_order_q.pop_front();
                if (out_item.out_tag !== want_item.out_tag)
                begin
                    $error("out_tag: expected %h, got %h", want_item.out_tag, out_item.out_tag);
                    mismatches++;
                end
                if (out_item.last_result !== want_item.last_result)
                begin
                    $error("last_result: expected %b, got %b",
                           want_item.last_result, out_item.last_result);
                    mismatches++;
                end
                if (out_item.overflow !== want_item.overflow)
                begin
                    $error("overflow: expected %b, got %b",
                           want_item.overflow, out_item.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        tdos_pkg::in_item_t  it;
        tdos_pkg::out_item_t want;
        // Drop reset just after time zero so the asynchronous reset sees an edge
        #1 rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed plan
        tx_idle_pct = 38;
        rx_idle_pct = 81;
        for (int row = 0; row < DIR_ROWS; row++)
        begin
            if (plan[row].kind == ROW_ORDER)
                write_order(plan[row].order);
            else
            begin
                it.geometry_tag  = plan[row].tag;
                it.transparent   = plan[row].transp;
                it.distance_key  = plan[row].key;
                it.last_item     = plan[row].last;
                want.out_tag     = plan[row].want_tag;
                want.last_result = plan[row].want_last;
                want.overflow    = plan[row].want_ovf;
                send_item(it, plan[row].typed, want);
            end
        end

        // Random frames under three idling regimes
        run_frames(60, 1'b0);
        write_order(1'b1);
        tx_idle_pct = 81;
        rx_idle_pct = 38;
        run_frames(60, 1'b0);
        write_order(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_frames(60, 1'b1);

        wait_drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tdos_pkg.sv
rtl/tdos_cell.sv
rtl/transparent_draw_order_sorter_top.sv
tb/sv/tb_transparent_draw_order_sorter_top.sv
